// ===== hdl/tats_pkg.sv =====
// Shared types, constants and helpers for the thermostat actuator test sequencer.
// No dependencies; used by tats_step and thermostat_actuator_test_sequencer.
`default_nettype none

package tats_pkg;

  localparam int unsigned CODE_W   = 8;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DWELL_W  = 8;
  localparam int unsigned TIME_W   = 9;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PHASE_W  = 2;

  localparam logic [POS_W-1:0]   POS_CAP   = 8'd200;
  localparam logic [DWELL_W-1:0] DWELL_CAP = 8'd250;
  localparam logic [TIME_W-1:0]  TIME_CAP  = 9'd500;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEL_CODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_POS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_POS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ON_DWELL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_DWELL = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_END_HOLD  = 3'd6;

  // phase codes as seen on the result stream
  localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_CODE_HIGH = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_CODE_LOW  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_CODE_END  = 2'd3;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_HIGH = 4'b0010,
    PH_LOW  = 4'b0100,
    PH_END  = 4'b1000
  } phase_t;

  // registers are held already saturated
  typedef struct packed {
    logic [CODE_W-1:0]  sel_code;
    logic [POS_W-1:0]   high_pos;
    logic [POS_W-1:0]   low_pos;
    logic [DWELL_W-1:0] on_dwell;
    logic [DWELL_W-1:0] off_dwell;
    logic [TIME_W-1:0]  total;
    logic [TIME_W-1:0]  end_hold;
  } cfg_t;

  typedef struct packed {
    phase_t             phase;
    logic [DWELL_W-1:0] dwell_left;
    logic [TIME_W-1:0]  total_left;
    logic [TIME_W-1:0]  hold_left;
    logic [POS_W-1:0]   position;
  } seq_state_t;

  function automatic logic [POS_W-1:0] cap_pos(input logic [POS_W-1:0] v);
    return (v > POS_CAP) ? POS_CAP : v;
  endfunction

  function automatic logic [DWELL_W-1:0] cap_dwell(input logic [DWELL_W-1:0] v);
    return (v > DWELL_CAP) ? DWELL_CAP : v;
  endfunction

  function automatic logic [TIME_W-1:0] cap_time(input logic [CFG_DATA_W-1:0] v);
    return (v > CFG_DATA_W'(TIME_CAP)) ? TIME_CAP : v[TIME_W-1:0];
  endfunction

  function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
    logic [PHASE_W-1:0] c;
    unique case (p)
      PH_IDLE: c = PHASE_CODE_IDLE;
      PH_HIGH: c = PHASE_CODE_HIGH;
      PH_LOW:  c = PHASE_CODE_LOW;
      PH_END:  c = PHASE_CODE_END;
      default: c = PHASE_CODE_IDLE;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/thermostat_actuator_test_sequencer.sv =====
// Top level of the thermostat actuator test sequencer: stream ports, config
// registers, sequencer state and result register. Depends on tats_pkg, tats_step.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  s_tdata: test_action_code, service_enable
//   m_*      out  m_tvalid/m_tready  m_tdata: in_progress, test_complete,
//                                             requested_position, phase
//   cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// One tick per cycle while not stalled; each tick's result is registered at its transfer.
// The state update and the result register load in the same edge.
// s_tready drops only while a result is held and m_tready is low.
// Reset: idle phase, cfg and state zero, no result pending. cfg_ready is always high.
`default_nettype none

module thermostat_actuator_test_sequencer (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [15:0]                      s_tdata,  // [7:0] test_action_code, [8] service_enable
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [15:0]                           m_tdata,  // [0] in_progress, [1] test_complete,
                                                          // [9:2] requested_position, [11:10] phase
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [tats_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [tats_pkg::CFG_DATA_W-1:0]  cfg_data
);

  tats_pkg::cfg_t       cfg;
  tats_pkg::seq_state_t st;
  tats_pkg::seq_state_t st_next;
  logic                 ena;
  logic                 accept;
  logic                 driving;
  logic                 ending;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign accept    = s_tvalid && s_tready;
  assign ena       = (s_tdata[7:0] == cfg.sel_code) && s_tdata[8];

  tats_step u_step (
    .st      (st),
    .cfg     (cfg),
    .ena     (ena),
    .st_next (st_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        tats_pkg::CFG_SEL_CODE:  cfg.sel_code  <= cfg_data[7:0];
        tats_pkg::CFG_HIGH_POS:  cfg.high_pos  <= tats_pkg::cap_pos(cfg_data[7:0]);
        tats_pkg::CFG_LOW_POS:   cfg.low_pos   <= tats_pkg::cap_pos(cfg_data[7:0]);
        tats_pkg::CFG_ON_DWELL:  cfg.on_dwell  <= tats_pkg::cap_dwell(cfg_data[7:0]);
        tats_pkg::CFG_OFF_DWELL: cfg.off_dwell <= tats_pkg::cap_dwell(cfg_data[7:0]);
        tats_pkg::CFG_TOTAL:     cfg.total     <= tats_pkg::cap_time(cfg_data);
        tats_pkg::CFG_END_HOLD:  cfg.end_hold  <= tats_pkg::cap_time(cfg_data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase      <= tats_pkg::PH_IDLE;
      st.dwell_left <= '0;
      st.total_left <= '0;
      st.hold_left  <= '0;
      st.position   <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (accept) begin
        st       <= st_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign driving = (st_next.phase == tats_pkg::PH_HIGH) || (st_next.phase == tats_pkg::PH_LOW);
  assign ending  = (st_next.phase == tats_pkg::PH_END);

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {4'b0000, tats_pkg::phase_code(st_next.phase), st_next.position,
                  ending, driving};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tats_step.sv =====
// Next-state logic of the test sequencer for one tick.
// Depends on tats_pkg.
`default_nettype none

module tats_step (
  input  wire tats_pkg::seq_state_t st,
  input  wire tats_pkg::cfg_t       cfg,
  input  wire logic                 ena,
  output tats_pkg::seq_state_t      st_next
);

  always_comb begin
    st_next = st;
    unique case (st.phase)
      tats_pkg::PH_IDLE: begin
        if (ena) begin
          st_next.phase      = tats_pkg::PH_HIGH;
          st_next.position   = cfg.high_pos;
          st_next.dwell_left = cfg.on_dwell;
          st_next.total_left = cfg.total;
        end
      end
      tats_pkg::PH_HIGH, tats_pkg::PH_LOW: begin
        if (!ena) begin
          st_next.phase    = tats_pkg::PH_IDLE;
          st_next.position = '0;
        end else if (st.total_left <= tats_pkg::TIME_W'(1)) begin
          st_next.phase     = tats_pkg::PH_END;
          st_next.position  = '0;
          st_next.hold_left = cfg.end_hold;
        end else begin
          st_next.total_left = st.total_left - tats_pkg::TIME_W'(1);
          if (st.dwell_left <= tats_pkg::DWELL_W'(1)) begin
            if (st.phase == tats_pkg::PH_HIGH) begin
              st_next.phase      = tats_pkg::PH_LOW;
              st_next.position   = cfg.low_pos;
              st_next.dwell_left = cfg.off_dwell;
            end else begin
              st_next.phase      = tats_pkg::PH_HIGH;
              st_next.position   = cfg.high_pos;
              st_next.dwell_left = cfg.on_dwell;
            end
          end else begin
            st_next.dwell_left = st.dwell_left - tats_pkg::DWELL_W'(1);
          end
        end
      end
      tats_pkg::PH_END: begin
        if (ena && (st.hold_left == '0)) begin
          st_next.phase    = tats_pkg::PH_IDLE;
          st_next.position = '0;
        end else if (st.hold_left != '0) begin
          st_next.hold_left = st.hold_left - tats_pkg::TIME_W'(1);
        end
      end
      default: begin
        st_next.phase    = tats_pkg::PH_IDLE;
        st_next.position = '0;
      end
    endcase
  end

endmodule

`default_nettype wire
